// ----- rtl/bnc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bnc_pkg;

    // Characters that the front end recognizes.
    localparam logic [7:0] CH_OPEN_PAREN  = 8'h28;
    localparam logic [7:0] CH_CLOSE_PAREN = 8'h29;
    localparam logic [7:0] CH_OPEN_SQ     = 8'h5B;
    localparam logic [7:0] CH_CLOSE_SQ    = 8'h5D;
    localparam logic [7:0] CH_OPEN_CURLY  = 8'h7B;
    localparam logic [7:0] CH_CLOSE_CURLY = 8'h7D;
    localparam logic [7:0] CH_OPEN_ANGLE  = 8'h3C;
    localparam logic [7:0] CH_CLOSE_ANGLE = 8'h3E;

    // Closer codes kept on the stack.
    localparam logic [1:0] CODE_PAREN = 2'd0;
    localparam logic [1:0] CODE_SQ    = 2'd1;
    localparam logic [1:0] CODE_CURLY = 2'd2;
    localparam logic [1:0] CODE_ANGLE = 2'd3;

    // Operation kinds passed from the front end to the stack engine.
    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_EOL  = 2'd2;

    // Line status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CORRUPT  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam int SCORE_W = 56;
    localparam int COUNT_W = 5;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] code;
    } op_t;

    // Handshake between the queue and the stack engine.
    typedef struct packed {
        logic empty;
        op_t  head;
    } q_stat_t;

endpackage

`default_nettype wire

// ----- rtl/bnc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bnc_front (
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic         mode,
    input  wire logic [7:0]   ch,
    input  wire logic         q_full,
    output logic              q_push,
    output bnc_pkg::op_t      q_data
);
    import bnc_pkg::*;

    logic keep;

    // Decode one character beat into a stack operation; other characters drop.
    always_comb
    begin
        q_data.kind = OP_EOL;
        q_data.code = CODE_PAREN;
        keep        = 1'b1;
        if (!mode)
        begin
            unique case (ch)
                CH_OPEN_PAREN:  begin q_data.kind = OP_PUSH; q_data.code = CODE_PAREN; end
                CH_OPEN_SQ:     begin q_data.kind = OP_PUSH; q_data.code = CODE_SQ;    end
                CH_OPEN_CURLY:  begin q_data.kind = OP_PUSH; q_data.code = CODE_CURLY; end
                CH_OPEN_ANGLE:  begin q_data.kind = OP_PUSH; q_data.code = CODE_ANGLE; end
                CH_CLOSE_PAREN: begin q_data.kind = OP_POP;  q_data.code = CODE_PAREN; end
                CH_CLOSE_SQ:    begin q_data.kind = OP_POP;  q_data.code = CODE_SQ;    end
                CH_CLOSE_CURLY: begin q_data.kind = OP_POP;  q_data.code = CODE_CURLY; end
                CH_CLOSE_ANGLE: begin q_data.kind = OP_POP;  q_data.code = CODE_ANGLE; end
                default:        keep = 1'b0;
            endcase
        end
    end

    // Accept whenever the queue has room.
    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full && keep;

endmodule

`default_nettype wire

// ----- rtl/bnc_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bnc_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire bnc_pkg::op_t  push_data,
    output logic               full,
    input  wire logic          pop,
    output bnc_pkg::q_stat_t   stat
);
    import bnc_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = 2;

    op_t              entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;

    assign full       = (count_reg == (PTR_W+1)'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.head  = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/bnc_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bnc_back #(
    parameter int STACK_DEPTH = 24
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire bnc_pkg::q_stat_t           q_stat,
    output logic                            q_pop,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [1:0]                      status,
    output logic [bnc_pkg::SCORE_W-1:0]     completion_score,
    output logic [bnc_pkg::COUNT_W-1:0]     open_count
);
    import bnc_pkg::*;

    localparam int LVL_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    localparam logic S_RUN  = 1'b0;
    localparam logic S_WALK = 1'b1;

    logic               state_reg, state_next;
    logic [LVL_W-1:0]   level_reg, level_next;
    logic [1:0]         line_st_reg, line_st_next;
    logic [LVL_W-1:0]   walk_reg, walk_next;
    logic [SCORE_W-1:0] score_reg, score_next;

    logic               out_valid_reg, out_valid_next;
    logic [1:0]         out_status_reg, out_status_next;
    logic [SCORE_W-1:0] out_score_reg, out_score_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;

    logic [1:0]         stack_reg [STACK_DEPTH];
    logic               stack_we;
    logic [IDX_W-1:0]   stack_wa;
    logic [1:0]         stack_wd;
    logic [LVL_W-1:0]   rd_sel;
    logic [LVL_W-1:0]   rd_lvl;
    logic [1:0]         rd_code;
    logic               out_free;

    // One read port: the top entry while running, the walk position otherwise.
    assign rd_sel  = (state_reg == S_WALK) ? walk_reg : level_reg;
    assign rd_lvl  = rd_sel - 1'b1;
    assign rd_code = stack_reg[rd_lvl[IDX_W-1:0]];

    assign out_free = !out_valid_reg || out_ready;

    // Stack engine and score walk.
    always_comb
    begin
        state_next      = state_reg;
        level_next      = level_reg;
        line_st_next    = line_st_reg;
        walk_next       = walk_reg;
        score_next      = score_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_score_next  = out_score_reg;
        out_count_next  = out_count_reg;
        q_pop           = 1'b0;
        stack_we        = 1'b0;
        stack_wa        = level_reg[IDX_W-1:0];
        stack_wd        = q_stat.head.code;

        unique case (state_reg)
            S_RUN:
            begin
                if (!q_stat.empty)
                begin
                    q_pop = 1'b1;
                    unique case (q_stat.head.kind)
                        OP_PUSH:
                        begin
                            if (level_reg < LVL_W'(STACK_DEPTH))
                            begin
                                stack_we   = 1'b1;
                                level_next = level_reg + 1'b1;
                            end
                            else if (line_st_reg == ST_OK)
                            begin
                                line_st_next = ST_OVERFLOW;
                            end
                        end
                        OP_POP:
                        begin
                            if (level_reg != '0 && rd_code == q_stat.head.code)
                            begin
                                level_next = level_reg - 1'b1;
                            end
                            else if (line_st_reg == ST_OK)
                            begin
                                line_st_next = ST_CORRUPT;
                            end
                        end
                        OP_EOL:
                        begin
                            walk_next  = (line_st_reg == ST_OK) ? level_reg : '0;
                            score_next = '0;
                            state_next = S_WALK;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                if (walk_reg != '0)
                begin
                    // score = score * 5 + digit, digit = code + 1
                    score_next = (score_reg << 2) + score_reg
                                 + SCORE_W'(rd_code) + SCORE_W'(1);
                    walk_next  = walk_reg - 1'b1;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = line_st_reg;
                    out_score_next  = score_reg;
                    out_count_next  = COUNT_W'(level_reg);
                    level_next      = '0;
                    line_st_next    = ST_OK;
                    state_next      = S_RUN;
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            level_reg     <= '0;
            line_st_reg   <= ST_OK;
            walk_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            line_st_reg   <= line_st_next;
            walk_reg      <= walk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        score_reg      <= score_next;
        out_status_reg <= out_status_next;
        out_score_reg  <= out_score_next;
        out_count_reg  <= out_count_next;
    end

    // Stack storage.
    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_reg[stack_wa] <= stack_wd;
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = out_status_reg;
    assign completion_score = out_score_reg;
    assign open_count       = out_count_reg;

endmodule

`default_nettype wire

// ----- rtl/bracket_nesting_checker_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Bracket nesting checker. Characters of a line arrive one beat at a time
// (mode 0); an end-of-line beat (mode 1) returns one result with the line's
// status, its base-5 completion score and the count of unclosed brackets, and
// clears the line state. A front end decodes each beat and drops plain
// characters; bracket and end-of-line beats go through a four-entry queue to
// the stack engine, which handles one bracket per cycle outside an end-of-line
// walk, so the input takes one beat per cycle while the queue has room. An
// end-of-line beat occupies the stack engine until its result is loaded: on a
// valid line the score is built by walking the stack one entry per cycle with
// a multiply-by-five accumulate (a corrupted or overflowed line skips the
// walk), then the engine waits for the output register to empty and loads
// the result into it. A result waiting in the output register does not stop
// the engine from taking further bracket beats.

module bracket_nesting_checker_unit #(
    parameter int STACK_DEPTH = 24
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       mode,
    input  wire logic [7:0]                 ch,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [1:0]                      status,
    output logic [bnc_pkg::SCORE_W-1:0]     completion_score,
    output logic [bnc_pkg::COUNT_W-1:0]     open_count
);
    import bnc_pkg::*;

    logic    q_full;
    logic    q_push;
    op_t     q_data;
    logic    q_pop;
    q_stat_t q_stat;

    bnc_front u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mode     (mode),
        .ch       (ch),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_data)
    );

    bnc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .pop       (q_pop),
        .stat      (q_stat)
    );

    bnc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_stat           (q_stat),
        .q_pop            (q_pop),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .completion_score (completion_score),
        .open_count       (open_count)
    );

endmodule

`default_nettype wire
